/* sv/esc_pkg.sv */
package esc_pkg;

   localparam int ID_W      = 32;
   localparam int TIME_W    = 64;
   localparam int CFG_W     = 32;
   localparam int CSR_IDX_W = 8;

   typedef logic [ID_W-1:0]      id_type;
   typedef logic [TIME_W-1:0]    time_type;
   typedef logic [CFG_W-1:0]     cfg_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   typedef enum logic [1:0] {
      KIND_MOVE   = 2'd0,
      KIND_RESIZE = 2'd1,
      KIND_TICK   = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ACT_MOVE  = 2'd0,
      ACT_FULL  = 2'd1,
      ACT_QUICK = 2'd2,
      ACT_HIDE  = 2'd3
   } action_type;

   localparam csr_idx_type REG_STORM_WINDOW = 8'd0;
   localparam csr_idx_type REG_JOIN_WINDOW  = 8'd1;
   localparam csr_idx_type REG_QUIET        = 8'd2;
   localparam csr_idx_type REG_SLACK        = 8'd3;

   localparam cfg_type STORM_WINDOW_RESET = 32'd30000000;
   localparam cfg_type JOIN_WINDOW_RESET  = 32'd10000000;
   localparam cfg_type QUIET_RESET        = 32'd50000000;
   localparam cfg_type SLACK_RESET        = 32'd1000000;

   // commands from the sequencer to the id chain
   typedef struct packed {
      logic   insert;
      logic   pop;
      id_type probe_id;
   } chain_ctl_type;

   // status of the id chain back to the sequencer
   typedef struct packed {
      logic   hit;
      logic   full;
      logic   empty;
      logic   one_left;
      id_type head_id;
   } chain_sts_type;

endpackage

/* sv/esc_req_if.sv */
interface esc_req_if;
   import esc_pkg::*;

   logic     valid;
   logic     ready;
   logic [1:0] kind;
   id_type   object_id;
   time_type now_ns;

   modport source (output valid, output kind, output object_id, output now_ns, input ready);
   modport sink   (input valid, input kind, input object_id, input now_ns, output ready);

endinterface

/* sv/esc_rsp_if.sv */
interface esc_rsp_if;
   import esc_pkg::*;

   logic       valid;
   logic       ready;
   logic [1:0] action;
   id_type     target_id;
   logic       last_of_run;

   modport source (output valid, output action, output target_id, output last_of_run,
                   input ready);
   modport sink   (input valid, input action, input target_id, input last_of_run,
                   output ready);

endinterface

/* sv/esc_csr_if.sv */
interface esc_csr_if;
   import esc_pkg::*;

   logic        valid;
   logic        ready;
   csr_idx_type index;
   cfg_type     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);

endinterface

/* sv/esc_cell.sv */
module esc_cell
   import esc_pkg::*;
(
   input  logic   clock,
   input  logic   load,
   input  logic   shift,
   input  logic   valid,
   input  id_type load_id,
   input  id_type next_id,
   input  id_type probe_id,
   output id_type id,
   output logic   match
);

   id_type id_ff;
   id_type id_in;

   always_comb begin
      id_in = id_ff;
      if (load) begin
         id_in = load_id;
      end else if (shift) begin
         id_in = next_id;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign id    = id_ff;
   assign match = valid && (id_ff == probe_id);

endmodule

/* sv/esc_chain.sv */
module esc_chain
   import esc_pkg::*;
#(
   parameter int SET_DEPTH = 8
)
(
   input  logic          clock,
   input  logic          reset,
   input  chain_ctl_type ctl,
   output chain_sts_type sts
);

   localparam int CNT_W = $clog2(SET_DEPTH + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   id_type             cell_id [SET_DEPTH];
   logic [SET_DEPTH-1:0] cell_match;

   // insertion order runs from cell 0; a pop hands every id one cell down
   for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
      id_type next_id;
      if (i == SET_DEPTH - 1) begin : g_tail
         assign next_id = cell_id[i];
      end else begin : g_body
         assign next_id = cell_id[i+1];
      end

      esc_cell u_cell (
         .clock    (clock),
         .load     (ctl.insert && (count_ff == CNT_W'(i))),
         .shift    (ctl.pop),
         .valid    (CNT_W'(i) < count_ff),
         .load_id  (ctl.probe_id),
         .next_id  (next_id),
         .probe_id (ctl.probe_id),
         .id       (cell_id[i]),
         .match    (cell_match[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign sts.hit      = |cell_match;
   assign sts.full     = (count_ff == CNT_W'(SET_DEPTH));
   assign sts.empty    = (count_ff == '0);
   assign sts.one_left = (count_ff == CNT_W'(1));
   assign sts.head_id  = cell_id[0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SET_DEPTH))
      else $error("id chain count beyond depth");

   a_no_insert_pop: assert property (@(posedge clock) disable iff (reset)
      !(ctl.insert && ctl.pop))
      else $error("insert and pop in the same cycle");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      ctl.insert |-> (!sts.full && !sts.hit))
      else $error("insert into full chain or of a stored id");

endmodule

/* sv/event_storm_coalescing_deferral_unit.sv */
// Event storm coalescing and deferral unit. Move, resize and tick events arrive
// on req_bus; rsp_bus returns the actions they cause, last_of_run marking the
// final one of each event. A move of another id inside the storm window, or any
// move or resize while a run is pending, defers the id into a set of SET_DEPTH
// ids held in a shift chain and answers hide (quick update when the set is full and lacks the id).
// A tick at or past the earliest deadline flushes the set in insertion order.
// Flow: an event is taken only in S_IDLE, goes through S_DECIDE and then gives
// its results one per cycle (a flush gives one result per stored id) while
// rsp_bus is not stalled; the next event waits until the unit is idle again.
// Registers are written through csr_bus while the unit is idle, a rule left to the user.
module event_storm_coalescing_deferral_unit
   import esc_pkg::*;
#(
   parameter int SET_DEPTH = 8
)
(
   input  logic clock,
   input  logic reset,
   esc_req_if.sink   req_bus,
   esc_rsp_if.source rsp_bus,
   esc_csr_if.sink   csr_bus
);

   typedef enum logic [5:0] {
      S_IDLE       = 6'b000001,
      S_DECIDE     = 6'b000010,
      S_SINGLE     = 6'b000100,
      S_DEFER_PREV = 6'b001000,
      S_DEFER_CUR  = 6'b010000,
      S_FLUSH      = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   cfg_type storm_ff, storm_in;
   cfg_type join_ff, join_in;
   cfg_type quiet_ff, quiet_in;
   cfg_type slack_ff, slack_in;

   logic     run_pending_ff, run_pending_in;
   time_type earliest_ff, earliest_in;
   time_type latest_ff, latest_in;
   id_type   last_move_id_ff, last_move_id_in;
   time_type last_move_time_ff, last_move_time_in;

   kind_type   kind_ff, kind_in;
   id_type     id_ff, id_in;
   time_type   now_ff, now_in;
   id_type     prev_id_ff, prev_id_in;
   time_type   dl_ff, dl_in;
   action_type single_ff, single_in;

   logic       rsp_valid_ff, rsp_valid_in;
   action_type rsp_action_ff, rsp_action_in;
   id_type     rsp_target_ff, rsp_target_in;
   logic       rsp_last_ff, rsp_last_in;

   chain_ctl_type chain_ctl;
   chain_sts_type chain_sts;

   logic     req_accept;
   logic     out_free;
   time_type gap;
   time_type latest_gap;
   logic [TIME_W:0] dl_sum;
   logic     near;
   logic     joined;
   logic     expire;
   logic     trail;
   logic     stored;

   esc_chain #(.SET_DEPTH(SET_DEPTH)) u_chain (
      .clock (clock),
      .reset (reset),
      .ctl   (chain_ctl),
      .sts   (chain_sts)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.action      = rsp_action_ff;
   assign rsp_bus.target_id   = rsp_target_ff;
   assign rsp_bus.last_of_run = rsp_last_ff;

   // gaps wrap modulo 2^64, so a step back in time looks like a huge gap
   assign gap        = now_ff - last_move_time_ff;
   assign latest_gap = latest_ff - now_ff;
   assign dl_sum     = {1'b0, now_ff} + {{(TIME_W - CFG_W + 1){1'b0}}, quiet_ff};
   assign near       = (last_move_id_ff != '0) && (last_move_id_ff != id_ff)
                       && (gap < {{(TIME_W - CFG_W){1'b0}}, storm_ff});
   assign joined     = (last_move_id_ff != '0) && (last_move_id_ff == id_ff)
                       && (gap < {{(TIME_W - CFG_W){1'b0}}, join_ff});
   assign expire     = run_pending_ff && (now_ff >= earliest_ff);
   assign trail      = (latest_ff > now_ff)
                       && (latest_gap > {{(TIME_W - CFG_W){1'b0}}, slack_ff});
   assign stored     = chain_sts.hit || !chain_sts.full;

   always_comb begin
      storm_in = storm_ff;
      join_in  = join_ff;
      quiet_in = quiet_ff;
      slack_in = slack_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_STORM_WINDOW: storm_in = csr_bus.data;
            REG_JOIN_WINDOW:  join_in  = csr_bus.data;
            REG_QUIET:        quiet_in = csr_bus.data;
            REG_SLACK:        slack_in = csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in          = state_ff;
      run_pending_in    = run_pending_ff;
      earliest_in       = earliest_ff;
      latest_in         = latest_ff;
      last_move_id_in   = last_move_id_ff;
      last_move_time_in = last_move_time_ff;
      kind_in           = kind_ff;
      id_in             = id_ff;
      now_in            = now_ff;
      prev_id_in        = prev_id_ff;
      dl_in             = dl_ff;
      single_in         = single_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_bus.ready;
      rsp_action_in     = rsp_action_ff;
      rsp_target_in     = rsp_target_ff;
      rsp_last_in       = rsp_last_ff;
      chain_ctl.insert  = 1'b0;
      chain_ctl.pop     = 1'b0;
      chain_ctl.probe_id = (state_ff == S_DEFER_PREV) ? prev_id_ff : id_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               kind_in  = kind_type'(req_bus.kind);
               id_in    = req_bus.object_id;
               now_in   = req_bus.now_ns;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // saturating deadline for any deferral of this event
            dl_in = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];
            case (kind_ff)
               KIND_MOVE: begin
                  prev_id_in        = last_move_id_ff;
                  last_move_id_in   = id_ff;
                  last_move_time_in = now_ff;
                  if (!run_pending_ff && !near) begin
                     single_in = ACT_MOVE;
                     state_in  = S_SINGLE;
                  end else if (near) begin
                     state_in = S_DEFER_PREV;
                  end else begin
                     state_in = S_DEFER_CUR;
                  end
               end
               KIND_RESIZE: begin
                  if (run_pending_ff) begin
                     state_in = S_DEFER_CUR;
                  end else begin
                     single_in = joined ? ACT_QUICK : ACT_FULL;
                     state_in  = S_SINGLE;
                  end
               end
               KIND_TICK: begin
                  state_in = S_IDLE;
                  if (expire) begin
                     // trailing run reuses the recorded latest deadline
                     if (trail) begin
                        run_pending_in = 1'b1;
                        earliest_in    = latest_ff;
                     end else begin
                        run_pending_in = 1'b0;
                        latest_in      = '0;
                     end
                     if (!chain_sts.empty) begin
                        state_in = S_FLUSH;
                     end
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SINGLE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_action_in = single_ff;
               rsp_target_in = id_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_DEFER_PREV, S_DEFER_CUR: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_action_in    = stored ? ACT_HIDE : ACT_QUICK;
               rsp_target_in    = chain_ctl.probe_id;
               rsp_last_in      = (state_ff == S_DEFER_CUR);
               chain_ctl.insert = !chain_sts.hit && !chain_sts.full;
               if (stored) begin
                  if (latest_ff < dl_ff) begin
                     latest_in = dl_ff;
                  end
                  if (!(run_pending_ff && (earliest_ff <= dl_ff))) begin
                     run_pending_in = 1'b1;
                     earliest_in    = dl_ff;
                  end
               end
               state_in = (state_ff == S_DEFER_PREV) ? S_DEFER_CUR : S_IDLE;
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_action_in = ACT_QUICK;
               rsp_target_in = chain_sts.head_id;
               rsp_last_in   = chain_sts.one_left;
               chain_ctl.pop = 1'b1;
               if (chain_sts.one_left) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         storm_ff          <= STORM_WINDOW_RESET;
         join_ff           <= JOIN_WINDOW_RESET;
         quiet_ff          <= QUIET_RESET;
         slack_ff          <= SLACK_RESET;
         run_pending_ff    <= 1'b0;
         earliest_ff       <= '0;
         latest_ff         <= '0;
         last_move_id_ff   <= '0;
         last_move_time_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         storm_ff          <= storm_in;
         join_ff           <= join_in;
         quiet_ff          <= quiet_in;
         slack_ff          <= slack_in;
         run_pending_ff    <= run_pending_in;
         earliest_ff       <= earliest_in;
         latest_ff         <= latest_in;
         last_move_id_ff   <= last_move_id_in;
         last_move_time_ff <= last_move_time_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      now_ff        <= now_in;
      prev_id_ff    <= prev_id_in;
      dl_ff         <= dl_in;
      single_ff     <= single_in;
      rsp_action_ff <= rsp_action_in;
      rsp_target_ff <= rsp_target_in;
      rsp_last_ff   <= rsp_last_in;
   end

   a_accept_decide: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_DECIDE))
      else $error("accepted transaction not decided next cycle");

   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH) |-> !chain_sts.empty)
      else $error("flush with an empty id chain");

   a_pending_deadline: assert property (@(posedge clock) disable iff (reset)
      run_pending_ff |-> (earliest_ff <= latest_ff))
      else $error("earliest deadline beyond latest deadline");

endmodule

/* test/event_storm_coalescing_deferral_unit_tb.sv */
module event_storm_coalescing_deferral_unit_tb;
   import esc_pkg::*;

   localparam int SET_DEPTH   = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 2 * SET_DEPTH + 16;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 28;
   localparam int DIR_N       = 26;
   localparam time_type T_END = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      kind_type   kind;
      id_type     id;
      time_type   now_ns;
      logic       typed;
      action_type act;
   } stim_row_type;

   typedef struct packed {
      action_type action;
      id_type     target_id;
      logic       last_of_run;
   } action_rec_type;

   typedef struct packed {
      cfg_type     storm;
      cfg_type     join_win;
      cfg_type     quiet;
      cfg_type     slack;
      logic [31:0] step;
   } cfg_set_type;

   // typed action applies only to single-result rows
   localparam stim_row_type DIR_ROWS [DIR_N] = '{
      '{KIND_MOVE,   32'h1,         64'd0,           1'b1, ACT_MOVE},
      '{KIND_RESIZE, 32'h1,         64'd1_000,       1'b1, ACT_QUICK},
      '{KIND_RESIZE, 32'h2,         64'd2_000,       1'b1, ACT_FULL},
      '{KIND_TICK,   32'h0,         64'd3_000,       1'b0, ACT_MOVE},
      '{KIND_MOVE,   32'h2,         64'd10_000_000,  1'b0, ACT_MOVE},
      '{KIND_MOVE,   32'h2,         64'd11_000_000,  1'b0, ACT_MOVE},
      '{KIND_RESIZE, 32'h3,         64'd12_000_000,  1'b0, ACT_MOVE},
      '{KIND_TICK,   32'h0,         64'd20_000_000,  1'b0, ACT_MOVE},
      '{KIND_TICK,   32'h0,         64'd60_000_000,  1'b0, ACT_MOVE},
      '{KIND_TICK,   32'h0,         64'd62_000_000,  1'b0, ACT_MOVE},
      '{KIND_NONE,   32'h5,         64'd63_000_000,  1'b0, ACT_MOVE},
      '{KIND_MOVE,   32'h10,        64'd100_000_000, 1'b1, ACT_MOVE},
      '{KIND_MOVE,   32'h11,        64'd101_000_000, 1'b0, ACT_MOVE},
      '{KIND_RESIZE, 32'h12,        64'd102_000_000, 1'b0, ACT_MOVE},
      '{KIND_RESIZE, 32'h13,        64'd103_000_000, 1'b0, ACT_MOVE},
      '{KIND_RESIZE, 32'h14,        64'd104_000_000, 1'b0, ACT_MOVE},
      '{KIND_RESIZE, 32'h15,        64'd105_000_000, 1'b0, ACT_MOVE},
      '{KIND_RESIZE, 32'h16,        64'd106_000_000, 1'b0, ACT_MOVE},
      '{KIND_RESIZE, 32'h17,        64'd107_000_000, 1'b0, ACT_MOVE},
      '{KIND_RESIZE, 32'hFFFF_FFFF, 64'd108_000_000, 1'b1, ACT_QUICK},
      '{KIND_RESIZE, 32'h0,         64'd109_000_000, 1'b1, ACT_QUICK},
      '{KIND_MOVE,   32'h20,        64'd50_000_000,  1'b0, ACT_MOVE},
      '{KIND_TICK,   32'h0,         T_END,           1'b0, ACT_MOVE},
      '{KIND_MOVE,   32'h30,        T_END,           1'b1, ACT_MOVE},
      '{KIND_MOVE,   32'h31,        T_END,           1'b0, ACT_MOVE},
      '{KIND_TICK,   32'h0,         T_END,           1'b0, ACT_MOVE}
   };

   localparam cfg_set_type PHASE_CFG [PHASES] = '{
      '{32'd1000, 32'd600, 32'd2500, 32'd200, 32'd1500},
      '{32'd0, 32'd0, 32'd0, 32'd0, 32'd100},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000},
      '{32'd3000, 32'd2000, 32'd1200, 32'd0, 32'd1500},
      '{32'd0, 32'd0, 32'd0, 32'd0, 32'd3000},
      '{STORM_WINDOW_RESET, JOIN_WINDOW_RESET, QUIET_RESET, SLACK_RESET, 32'd20_000_000}
   };

   logic clock = 1'b0;
   logic reset;

   esc_req_if req_bus();
   esc_rsp_if rsp_bus();
   esc_csr_if csr_bus();

   event_storm_coalescing_deferral_unit #(.SET_DEPTH(SET_DEPTH)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the unit's configuration and deferral state
   cfg_type  cfg_storm, cfg_join, cfg_quiet, cfg_slack;
   logic     run_armed;
   time_type first_deadline, last_deadline;
   id_type   prev_move_id;
   time_type prev_move_ns;
   id_type   hidden_ids [SET_DEPTH];
   int       hidden_n;

   action_rec_type fresh_actions[$];
   action_rec_type due_actions[$];

   int mismatches = 0;
   int cycles     = 0;
   int burst_left = 0;
   int stall_left = 0;
   int stall_mode = 0;
   int stall_tick = 0;

   task automatic flag_mismatch(string what);
      $display("MISMATCH @%0d: %s", cycles, what);
      mismatches++;
   endtask

   function automatic void arm_run(time_type deadline);
      if (last_deadline < deadline) last_deadline = deadline;
      if (!(run_armed && first_deadline <= deadline)) begin
         run_armed      = 1'b1;
         first_deadline = deadline;
      end
   endfunction

   function automatic void defer_id(id_type id, time_type now_v);
      logic     found = 1'b0;
      time_type deadline;
      for (int i = 0; i < hidden_n; i++)
         if (hidden_ids[i] == id) found = 1'b1;
      if (!found && hidden_n >= SET_DEPTH) begin
         fresh_actions.push_back('{ACT_QUICK, id, 1'b0});
         return;
      end
      if (!found) begin
         hidden_ids[hidden_n] = id;
         hidden_n++;
      end
      fresh_actions.push_back('{ACT_HIDE, id, 1'b0});
      deadline = now_v + cfg_quiet;
      if (deadline < now_v) deadline = T_END;
      arm_run(deadline);
   endfunction

   function automatic void predict_actions(kind_type kind, id_type id, time_type now_v);
      logic     storm;
      time_type latest;
      fresh_actions.delete();
      case (kind)
         KIND_MOVE: begin
            storm = prev_move_id != 0 && prev_move_id != id && (now_v - prev_move_ns) < cfg_storm;
            if (!run_armed && !storm) begin
               fresh_actions.push_back('{ACT_MOVE, id, 1'b0});
            end else begin
               if (storm) defer_id(prev_move_id, now_v);
               defer_id(id, now_v);
            end
            prev_move_id = id;
            prev_move_ns = now_v;
         end
         KIND_RESIZE: begin
            if (run_armed)
               defer_id(id, now_v);
            else if (prev_move_id != 0 && id == prev_move_id && (now_v - prev_move_ns) < cfg_join)
               fresh_actions.push_back('{ACT_QUICK, id, 1'b0});
            else
               fresh_actions.push_back('{ACT_FULL, id, 1'b0});
         end
         KIND_TICK: begin
            if (run_armed && now_v >= first_deadline) begin
               run_armed = 1'b0;
               for (int i = 0; i < hidden_n; i++)
                  fresh_actions.push_back('{ACT_QUICK, hidden_ids[i], 1'b0});
               hidden_n      = 0;
               latest        = last_deadline;
               last_deadline = '0;
               if (latest > now_v && (latest - now_v) > cfg_slack) arm_run(latest);
            end
         end
         default: ;
      endcase
      if (fresh_actions.size() > 0) fresh_actions[fresh_actions.size() - 1].last_of_run = 1'b1;
   endfunction

   task automatic pace_sender();
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
   endtask

   task automatic send_event(kind_type kind, id_type id, time_type now_v, logic typed,
                             action_type act);
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= kind;
      req_bus.object_id <= id;
      req_bus.now_ns    <= now_v;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_actions(kind, id, now_v);
      if (typed)
         due_actions.push_back('{act, id, 1'b1});
      else
         foreach (fresh_actions[i]) due_actions.push_back(fresh_actions[i]);
      pace_sender();
   endtask

   task automatic write_csr(csr_idx_type index, cfg_type value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (index)
         REG_STORM_WINDOW: cfg_storm = value;
         REG_JOIN_WINDOW:  cfg_join  = value;
         REG_QUIET:        cfg_quiet = value;
         REG_SLACK:        cfg_slack = value;
         default: ;
      endcase
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (due_actions.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      action_rec_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (due_actions.size() == 0) begin
            flag_mismatch($sformatf("unexpected transaction: action %0d id %h last %b",
                                    rsp_bus.action, rsp_bus.target_id, rsp_bus.last_of_run));
         end else begin
            want = due_actions.pop_front();
            if (rsp_bus.action !== want.action || rsp_bus.target_id !== want.target_id ||
                rsp_bus.last_of_run !== want.last_of_run)
               flag_mismatch($sformatf("action %0d id %h last %b, expected %0d %h %b",
                                       rsp_bus.action, rsp_bus.target_id, rsp_bus.last_of_run,
                                       want.action, want.target_id, want.last_of_run));
         end
      end
      // stall style is picked anew when stall_left runs out, mode 0 never stalls
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 96);
      end else begin
         stall_left--;
      end
      stall_tick++;
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= $urandom_range(0, 3) != 0;
         2: rsp_bus.ready <= (stall_tick % 5) != 0;
         default: rsp_bus.ready <= $urandom_range(0, 3) == 0;
      endcase
   end

   initial begin
      cfg_set_type cfg;
      time_type t;
      id_type   pool_base;
      id_type   id;
      kind_type kind;
      int       made;
      int       pick;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.kind      = KIND_NONE;
      req_bus.object_id = '0;
      req_bus.now_ns    = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;

      cfg_storm      = STORM_WINDOW_RESET;
      cfg_join       = JOIN_WINDOW_RESET;
      cfg_quiet      = QUIET_RESET;
      cfg_slack      = SLACK_RESET;
      run_armed      = 1'b0;
      first_deadline = '0;
      last_deadline  = '0;
      prev_move_id   = '0;
      prev_move_ns   = '0;
      hidden_n       = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(1, 20);

      for (int i = 0; i < DIR_N; i++)
         send_event(DIR_ROWS[i].kind, DIR_ROWS[i].id, DIR_ROWS[i].now_ns, DIR_ROWS[i].typed,
                    DIR_ROWS[i].act);

      for (int p = 0; p < PHASES; p++) begin
         cfg = PHASE_CFG[p];
         if (p == 4)
            cfg = '{cfg_type'($urandom_range(0, 8000)), cfg_type'($urandom_range(0, 8000)),
                    cfg_type'($urandom_range(0, 8000)), cfg_type'($urandom_range(0, 8000)),
                    32'd3000};
         drain();
         write_csr(REG_STORM_WINDOW, cfg.storm);
         write_csr(REG_JOIN_WINDOW, cfg.join_win);
         write_csr(REG_QUIET, cfg.quiet);
         write_csr(REG_SLACK, cfg.slack);
         // index past the register file, must be ignored
         write_csr(csr_idx_type'($urandom_range(4, 255)), $urandom);
         csr_bus.valid <= 1'b0;

         // all-ones phase starts close to the top so deadlines saturate
         t = (p == 2) ? {32'hFFFF_FFFF, $urandom} : {$urandom, $urandom};
         pool_base = $urandom;
         made = 0;
         while (made < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            kind = pick < 3 ? KIND_NONE : pick < 45 ? KIND_MOVE : pick < 70 ? KIND_RESIZE
                                                                            : KIND_TICK;
            // a pool larger than the set so that it fills and repeats often
            pick = $urandom_range(0, 19);
            id = pick == 0 ? id_type'(0) : pick == 1 ? id_type'($urandom)
                                                     : pool_base + $urandom_range(0, 11);
            pick = $urandom_range(0, 39);
            if (pick == 0)
               t = t - $urandom_range(0, cfg.step);
            else if (kind == KIND_TICK)
               t = t + time_type'($urandom_range(0, cfg.step)) * $urandom_range(0, 3);
            else
               t = t + $urandom_range(0, cfg.step / 2);
            send_event(kind, id, t, 1'b0, ACT_MOVE);
            if (kind != KIND_NONE) made++;
         end
      end

      drain();
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
